// File: src/wmf_pkg.sv
// shared types and constants of the window median filter
`timescale 1ns / 1ps

package wmf_pkg;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QCNT_W      = 3;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [COORD_W-1:0] coord_t;

    // position tag that travels with each window
    typedef struct packed {
        coord_t row;
        coord_t col;
        logic   frame_end;
    } meta_t;

endpackage

// File: src/wmf_front.sv
// front end: pixel counters, line memories and the sliding window
`timescale 1ns / 1ps

module wmf_front #(
    parameter int IMG_ROWS = 64,
    parameter int IMG_COLS = 128,
    parameter int WIN_SIZE = 3
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  wmf_pkg::pix_t                         pixel,
    input  logic [wmf_pkg::QCNT_W-1:0]            q_count,
    output logic                                  push,
    output logic [WIN_SIZE*WIN_SIZE*wmf_pkg::PIX_W-1:0] push_win,
    output wmf_pkg::meta_t                        push_meta
);

    localparam int LINES    = WIN_SIZE - 1;
    localparam int HALF_WIN = (WIN_SIZE - 1) / 2;
    localparam int COL_AW   = $clog2(IMG_COLS);
    localparam logic [wmf_pkg::COORD_W-1:0] OFS      = wmf_pkg::COORD_W'(WIN_SIZE - 1 - HALF_WIN);
    localparam logic [wmf_pkg::COORD_W-1:0] FIRST    = wmf_pkg::COORD_W'(WIN_SIZE - 1);
    localparam logic [wmf_pkg::COORD_W-1:0] LAST_ROW = wmf_pkg::COORD_W'(IMG_ROWS - 1);
    localparam logic [wmf_pkg::COORD_W-1:0] LAST_COL = wmf_pkg::COORD_W'(IMG_COLS - 1);

    wmf_pkg::pix_t line_mem [LINES][IMG_COLS];

    wmf_pkg::coord_t row_reg, row_next;
    wmf_pkg::coord_t col_reg, col_next;
    logic            s1_valid_reg;
    wmf_pkg::pix_t   s1_pix_reg;
    logic [COL_AW-1:0] s1_addr_reg;
    logic            s1_prod_reg;
    wmf_pkg::meta_t  s1_meta_reg;
    wmf_pkg::pix_t   rd_reg [LINES];
    wmf_pkg::pix_t   win_reg  [WIN_SIZE][WIN_SIZE];
    wmf_pkg::pix_t   win_next [WIN_SIZE][WIN_SIZE];
    wmf_pkg::pix_t   new_col  [WIN_SIZE];
    logic            accept;
    logic [wmf_pkg::QCNT_W:0] pending;

    assign pending  = {1'b0, q_count} + (wmf_pkg::QCNT_W+1)'(s1_valid_reg);
    assign in_ready = pending < (wmf_pkg::QCNT_W+1)'(wmf_pkg::QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        col_next = col_reg + 8'd1;
        row_next = row_reg;
        if (col_reg == LAST_COL)
        begin
            col_next = '0;
            row_next = (row_reg == LAST_ROW) ? '0 : row_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    // read old column, then push it one line down the cascade
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg          <= pixel;
            s1_addr_reg         <= col_reg[COL_AW-1:0];
            s1_prod_reg         <= (row_reg >= FIRST) && (col_reg >= FIRST);
            s1_meta_reg.row     <= row_reg - OFS;
            s1_meta_reg.col     <= col_reg - OFS;
            s1_meta_reg.frame_end <= (row_reg == LAST_ROW) && (col_reg == LAST_COL);
            for (int k = 0; k < LINES; k++)
            begin
                rd_reg[k] <= line_mem[k][col_reg[COL_AW-1:0]];
            end
        end
        if (s1_valid_reg)
        begin
            line_mem[0][s1_addr_reg] <= s1_pix_reg;
            for (int k = 1; k < LINES; k++)
            begin
                line_mem[k][s1_addr_reg] <= rd_reg[k-1];
            end
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            new_col[i] = (i == WIN_SIZE - 1) ? s1_pix_reg : rd_reg[WIN_SIZE-2-i];
        end
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            for (int j = 0; j < WIN_SIZE; j++)
            begin
                win_next[i][j] = (j == WIN_SIZE - 1) ? new_col[i] : win_reg[i][j+1];
                push_win[(i*WIN_SIZE+j)*wmf_pkg::PIX_W +: wmf_pkg::PIX_W] = win_next[i][j];
            end
        end
    end

    assign push      = s1_valid_reg && s1_prod_reg;
    assign push_meta = s1_meta_reg;

endmodule

// File: src/wmf_queue.sv
// short queue of windows between front end and sorter
`timescale 1ns / 1ps

module wmf_queue #(
    parameter int WIN_BITS = 72
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIN_BITS-1:0]        push_win,
    input  wmf_pkg::meta_t             push_meta,
    input  logic                       pop,
    output logic                       q_valid,
    output logic [WIN_BITS-1:0]        q_win,
    output wmf_pkg::meta_t             q_meta,
    output logic [wmf_pkg::QCNT_W-1:0] q_count
);

    logic [WIN_BITS-1:0]         win_mem  [wmf_pkg::QUEUE_DEPTH];
    wmf_pkg::meta_t              meta_mem [wmf_pkg::QUEUE_DEPTH];
    logic [wmf_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [wmf_pkg::QCNT_W-1:0]  count_reg;
    logic                        do_pop;

    assign q_valid = count_reg != '0;
    assign do_pop  = pop && q_valid;
    assign q_win   = win_mem[rd_ptr_reg];
    assign q_meta  = meta_mem[rd_ptr_reg];
    assign q_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + wmf_pkg::QCNT_W'(push) - wmf_pkg::QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            win_mem[wr_ptr_reg]  <= push_win;
            meta_mem[wr_ptr_reg] <= push_meta;
        end
    end

endmodule

// File: src/wmf_sort.sv
// back end: odd-even transposition sort pipeline and median pick
`timescale 1ns / 1ps

module wmf_sort #(
    parameter int WIN_SIZE = 3
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    q_valid,
    input  logic [WIN_SIZE*WIN_SIZE*wmf_pkg::PIX_W-1:0] q_win,
    input  wmf_pkg::meta_t                          q_meta,
    output logic                                    pop,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output wmf_pkg::pix_t                           median,
    output wmf_pkg::coord_t                         out_row,
    output wmf_pkg::coord_t                         out_col,
    output logic                                    frame_end
);

    localparam int N = WIN_SIZE * WIN_SIZE;

    wmf_pkg::pix_t  stg_reg   [N][N];
    wmf_pkg::pix_t  layer_out [N][N];
    logic           stg_v_reg [N];
    wmf_pkg::meta_t stg_m_reg [N];
    logic           advance;
    logic           out_valid_reg;
    wmf_pkg::pix_t  median_reg;
    wmf_pkg::meta_t out_meta_reg;
    wmf_pkg::pix_t  pick;

    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance;

    for (genvar s = 0; s < N; s++)
    begin : g_layer
        wmf_pkg::pix_t lin [N];
        always_comb
        begin
            for (int i = 0; i < N; i++)
            begin
                if (s == 0)
                begin
                    lin[i] = q_win[i*wmf_pkg::PIX_W +: wmf_pkg::PIX_W];
                end
                else
                begin
                    lin[i] = stg_reg[(s == 0) ? 0 : s-1][i];
                end
            end
            for (int i = 0; i < N; i++)
            begin
                layer_out[s][i] = lin[i];
            end
            for (int i = s % 2; i + 1 < N; i += 2)
            begin
                if (lin[i] > lin[i+1])
                begin
                    layer_out[s][i]   = lin[i+1];
                    layer_out[s][i+1] = lin[i];
                end
            end
        end
    end

    if (N % 2 == 1)
    begin : g_odd
        assign pick = stg_reg[N-1][(N-1)/2];
    end
    else
    begin : g_even
        logic [wmf_pkg::PIX_W:0] sum;
        assign sum  = {1'b0, stg_reg[N-1][N/2-1]} + {1'b0, stg_reg[N-1][N/2]};
        assign pick = sum[wmf_pkg::PIX_W:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int s = 0; s < N; s++)
            begin
                stg_v_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            stg_v_reg[0] <= q_valid;
            for (int s = 1; s < N; s++)
            begin
                stg_v_reg[s] <= stg_v_reg[s-1];
            end
            out_valid_reg <= stg_v_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stg_m_reg[0] <= q_meta;
            for (int s = 1; s < N; s++)
            begin
                stg_m_reg[s] <= stg_m_reg[s-1];
            end
            stg_reg      <= layer_out;
            median_reg   <= pick;
            out_meta_reg <= stg_m_reg[N-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;
    assign out_row   = out_meta_reg.row;
    assign out_col   = out_meta_reg.col;
    assign frame_end = out_meta_reg.frame_end;

endmodule

// File: src/window_median_filter.sv
// top level of the streaming square-window median filter
// pixel to result: front-end stage, window queue, sort stages, output register
// one pixel per cycle while in_ready is high, set by the one-read one-write line memories
// the sort pipeline holds one compare layer per stage, one window enters per unstalled cycle
// reset clears counters, queue pointers and valid bits; memories and windows are not cleared
`timescale 1ns / 1ps

module window_median_filter #(
    parameter int IMG_ROWS = 64,
    parameter int IMG_COLS = 128,
    parameter int WIN_SIZE = 3
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      pixel,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      median,
    output logic [7:0]      out_row,
    output logic [7:0]      out_col,
    output logic            frame_end
);

    localparam int WIN_BITS = WIN_SIZE * WIN_SIZE * wmf_pkg::PIX_W;

    logic                       push, pop, q_valid;
    logic [WIN_BITS-1:0]        push_win, q_win;
    wmf_pkg::meta_t             push_meta, q_meta;
    logic [wmf_pkg::QCNT_W-1:0] q_count;

    wmf_front #(
        .IMG_ROWS (IMG_ROWS),
        .IMG_COLS (IMG_COLS),
        .WIN_SIZE (WIN_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .q_count   (q_count),
        .push      (push),
        .push_win  (push_win),
        .push_meta (push_meta)
    );

    wmf_queue #(
        .WIN_BITS (WIN_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_win  (push_win),
        .push_meta (push_meta),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_win     (q_win),
        .q_meta    (q_meta),
        .q_count   (q_count)
    );

    wmf_sort #(
        .WIN_SIZE (WIN_SIZE)
    ) u_sort (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_win     (q_win),
        .q_meta    (q_meta),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .median    (median),
        .out_row   (out_row),
        .out_col   (out_col),
        .frame_end (frame_end)
    );

endmodule

// File: src/wmf_checker.sv
// port checker for the median filter, bound to the top level
`timescale 1ns / 1ps

module wmf_checker #(
    parameter int IMG_ROWS = 64,
    parameter int IMG_COLS = 128,
    parameter int WIN_SIZE = 3
) (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] median,
    input logic [7:0] out_row,
    input logic [7:0] out_col,
    input logic       frame_end
);

    localparam int HALF_WIN = (WIN_SIZE - 1) / 2;
    localparam logic [7:0] ROW_MIN = 8'(HALF_WIN);
    localparam logic [7:0] ROW_MAX = 8'(IMG_ROWS - WIN_SIZE + HALF_WIN);
    localparam logic [7:0] COL_MAX = 8'(IMG_COLS - WIN_SIZE + HALF_WIN);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median) && $stable(out_row)
            && $stable(out_col) && $stable(frame_end))
        else $error("result changed while stalled");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_row >= ROW_MIN && out_row <= ROW_MAX)
        else $error("result row outside interior");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_col >= ROW_MIN && out_col <= COL_MAX)
        else $error("result column outside interior");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> out_row == ROW_MAX && out_col == COL_MAX)
        else $error("frame end not on last interior pixel");

endmodule

bind window_median_filter wmf_checker #(
    .IMG_ROWS (IMG_ROWS),
    .IMG_COLS (IMG_COLS),
    .WIN_SIZE (WIN_SIZE)
) u_wmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .median    (median),
    .out_row   (out_row),
    .out_col   (out_col),
    .frame_end (frame_end)
);

// File: dv/testbench.sv
// self-checking testbench of the window median filter
`timescale 1ns / 1ps

module testbench;

    localparam int ROWS = 64;
    localparam int COLS = 128;
    localparam int WIN  = 3;
    localparam int HALF = (WIN - 1) / 2;
    localparam int AREA = WIN * WIN;
    localparam int LAT  = AREA + 3;

    typedef struct packed {
        wmf_pkg::pix_t   med;
        wmf_pkg::coord_t row;
        wmf_pkg::coord_t col;
        logic            fend;
    } filt_res_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    wmf_pkg::pix_t   pixel = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    wmf_pkg::pix_t   median;
    wmf_pkg::coord_t out_row;
    wmf_pkg::coord_t out_col;
    logic            frame_end;

    window_median_filter #(.IMG_ROWS(ROWS), .IMG_COLS(COLS), .WIN_SIZE(WIN)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
        .out_valid(out_valid), .out_ready(out_ready),
        .median(median), .out_row(out_row), .out_col(out_col), .frame_end(frame_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    wmf_pkg::pix_t pixel_q[$];
    filt_res_t     median_q[$];
    wmf_pkg::pix_t lines[WIN][256];
    int            cur_row = 0;
    int            cur_col = 0;
    int            errors = 0;
    int            results_seen = 0;
    int            sent = 0;
    bit            stim_done = 1'b0;
    int            hold_off = 0;

    function automatic wmf_pkg::pix_t window_middle(input wmf_pkg::pix_t w[AREA]);
        wmf_pkg::pix_t s[AREA];
        wmf_pkg::pix_t v;
        int            b;
        s = w;
        for (int a = 1; a < AREA; a++)
        begin
            v = s[a];
            b = a;
            while (b > 0 && s[b-1] > v)
            begin
                s[b] = s[b-1];
                b--;
            end
            s[b] = v;
        end
        if (AREA % 2)
            return s[(AREA-1)/2];
        return wmf_pkg::pix_t'((int'(s[AREA/2-1]) + int'(s[AREA/2])) / 2);
    endfunction

    task automatic predict_pixel(input wmf_pkg::pix_t p);
        wmf_pkg::pix_t w[AREA];
        filt_res_t     e;
        int            top;
        int            left;
        lines[cur_row % WIN][cur_col] = p;
        if (cur_row >= WIN - 1 && cur_col >= WIN - 1)
        begin
            top  = cur_row - (WIN - 1);
            left = cur_col - (WIN - 1);
            for (int i = 0; i < WIN; i++)
                for (int j = 0; j < WIN; j++)
                    w[i*WIN+j] = lines[(top+i) % WIN][left+j];
            e.med  = window_middle(w);
            e.row  = wmf_pkg::coord_t'(top + HALF);
            e.col  = wmf_pkg::coord_t'(left + HALF);
            e.fend = (cur_row == ROWS-1 && cur_col == COLS-1);
            median_q.push_back(e);
        end
        cur_col++;
        if (cur_col >= COLS)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS)
                cur_row = 0;
        end
    endtask

    // stimulus: directed extremes then random runs of mixed texture
    initial
    begin
        int n;
        int mode;
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hff);
        pixel_q.push_back(8'h55);
        pixel_q.push_back(8'haa);
        for (int k = 0; k < 20; k++)
            pixel_q.push_back(k[0] ? 8'hff : 8'h00);
        n = 1150;
        while (pixel_q.size() < n)
        begin
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 64; k++)
                case (mode)
                    0: pixel_q.push_back(wmf_pkg::pix_t'($urandom));
                    1: pixel_q.push_back($urandom_range(0, 3) == 0 ? 8'hff : 8'h00);
                    2: pixel_q.push_back(wmf_pkg::pix_t'($urandom_range(120, 136)));
                    default: pixel_q.push_back(wmf_pkg::pix_t'(k * 4));
                endcase
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    int in_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_pixel(pixel);
                sent++;
            end
            if (in_valid && !in_ready)
                ;
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap--;
            end
            else if (pixel_q.size() > 0)
            begin
                in_valid <= 1'b1;
                pixel    <= pixel_q.pop_front();
                in_gap   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            end
            else
            begin
                in_valid  <= 1'b0;
                stim_done = 1'b1;
            end
        end
    end

    // receiver hold-off, long stall once early in the run
    initial
    begin
        wait (sent >= 200);
        hold_off = 300;
        while (hold_off > 0)
        begin
            @(posedge clk);
            hold_off--;
        end
    end

    // monitor
    int out_gap = 0;
    always @(posedge clk)
    begin
        filt_res_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (median_q.size() == 0)
                begin
                    $error("unexpected transfer row %0d col %0d", out_row, out_col);
                    errors++;
                end
                else
                begin
                    e = median_q.pop_front();
                    if (median !== e.med)
                    begin
                        $error("median exp %0d got %0d", e.med, median);
                        errors++;
                    end
                    if (out_row !== e.row)
                    begin
                        $error("out_row exp %0d got %0d", e.row, out_row);
                        errors++;
                    end
                    if (out_col !== e.col)
                    begin
                        $error("out_col exp %0d got %0d", e.col, out_col);
                        errors++;
                    end
                    if (frame_end !== e.fend)
                    begin
                        $error("frame_end exp %0d got %0d", e.fend, frame_end);
                        errors++;
                    end
                end
            end
            if (hold_off > 0)
                out_ready <= 1'b0;
            else if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    out_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            end
        end
    end

    initial
    begin
        wait (stim_done && median_q.size() == 0);
        repeat (LAT * 4) @(posedge clk);
        $display("sent %0d pixels of extremes, noise, flat and ramp texture with random gaps",
                 sent);
        $display("checked %0d filtered results, including a long output stall", results_seen);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
src/wmf_pkg.sv
src/wmf_front.sv
src/wmf_queue.sv
src/wmf_sort.sv
src/window_median_filter.sv
src/wmf_checker.sv
dv/testbench.sv
